// ----- hw/rtl/mi4_pkg.sv -----
// Shared widths, constants and helper functions for the 4x4 matrix inverse.
`timescale 1ns / 1ps
package mi4_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ELEM_W     = 32;
   localparam int LIMB_W     = 32;
   localparam int PROD_W     = 128;
   localparam int ADJ_W      = 98;
   localparam int ADJ_MAG_W  = 96;
   localparam int ACC_W      = 131;
   localparam int DMAG_W     = 130;
   localparam int DIV_W      = DMAG_W + 33;
   localparam int QUO_W      = 33;
   localparam int MIN_DET_W  = 31;
   localparam int NELEM      = 16;
   localparam int NPERM      = 6;

   typedef struct packed {
      logic start;
      logic neg;
   } div_ctl_type;

   // Column chosen by row i of permutation p of three columns.
   function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] i);
      logic [5:0] cols;
      case (p)
         3'd0:    cols = {2'd2, 2'd1, 2'd0};
         3'd1:    cols = {2'd1, 2'd2, 2'd0};
         3'd2:    cols = {2'd2, 2'd0, 2'd1};
         3'd3:    cols = {2'd0, 2'd2, 2'd1};
         3'd4:    cols = {2'd1, 2'd0, 2'd2};
         3'd5:    cols = {2'd0, 2'd1, 2'd2};
         default: cols = {2'd2, 2'd1, 2'd0};
      endcase
      case (i)
         2'd0:    perm_col = cols[1:0];
         2'd1:    perm_col = cols[3:2];
         2'd2:    perm_col = cols[5:4];
         default: perm_col = cols[1:0];
      endcase
   endfunction

   // Odd permutations carry a minus sign.
   function automatic logic perm_odd(input logic [2:0] p);
      case (p)
         3'd1, 3'd2, 3'd5: perm_odd = 1'b1;
         default:          perm_odd = 1'b0;
      endcase
   endfunction

   // Skip the excluded index when mapping 0..2 onto 0..3.
   function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] excl);
      skip_idx = (i >= excl) ? 2'(i + 2'd1) : i;
   endfunction

endpackage

// ----- hw/rtl/matrix4x4_inverse_adjugate.sv -----
// Top level: 4x4 matrix inverse by adjugate, with shared multiplier sequencer.
//
//   channel   ports                          direction
//   req       req_valid/req_ready            in,  one element per transfer
//   rsp       rsp_valid/rsp_ready            out, one inverse entry per transfer
//   csr       csr_wr_en/csr_wr_data          in,  min_det write
//
// A matrix takes 16 load transfers, then the cofactor work (96 terms of
// three elements through one 32x32 multiplier, limb by limb), then the
// determinant and the singular check, and then, unless the matrix is singular,
// one bit-serial division per entry before that entry's result transfer.
// Reset clears the sequencer and the load count and sets min_det to 1.
// The input side is ready only while loading; a stalled result holds the sequencer.
`timescale 1ns / 1ps
module matrix4x4_inverse_adjugate import mi4_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ELEM_W-1:0]    req_elem_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ELEM_W-1:0]    rsp_out_value,
   output logic [3:0]           rsp_out_index,
   output logic                 rsp_singular,
   output logic                 rsp_last_item,
   input  logic                 csr_wr_en,
   input  logic [MIN_DET_W-1:0] csr_wr_data
);

   typedef enum logic [3:0] {
      ST_LOAD, ST_FETCH, ST_MUL, ST_ACC, ST_DFETCH, ST_DMUL, ST_DACC,
      ST_DABS, ST_CHECK, ST_DIV, ST_OUT
   } state_type;

   state_type            state_ff;
   logic [3:0]           load_cnt_ff;
   logic [MIN_DET_W-1:0] min_det_ff;
   logic [3:0]           idx_ff;
   logic [2:0]           perm_ff;
   logic [1:0]           fac_ff;
   logic [1:0]           limb_ff;
   logic [1:0]           grp_ff;
   logic [PROD_W-1:0]    m_ff;
   logic [PROD_W-1:0]    p_ff;
   logic                 sgn_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [ADJ_W-1:0]     adj_ff [NELEM];
   logic [DMAG_W-1:0]    dmag_ff;
   logic                 det_neg_ff;
   logic                 div_start_ff;
   logic                 rsp_valid_ff;
   logic [ELEM_W-1:0]    rsp_value_ff;
   logic [3:0]           rsp_index_ff;
   logic                 rsp_sing_ff;
   logic                 rsp_last_ff;

   logic [3:0]           rd_addr;
   logic [ELEM_W-1:0]    rd_data;
   logic                 rd_neg;
   logic [LIMB_W-1:0]    rd_mag;
   logic [1:0]           term_grp;
   logic [1:0]           term_pos;
   logic                 base_sign;
   logic [LIMB_W-1:0]    m_limb;
   logic [2*LIMB_W-1:0]  limb_prod;
   logic [PROD_W-1:0]    p_in;
   logic [ACC_W-1:0]     acc_in;
   logic [3:0]           adj_rd_idx;
   logic [ADJ_W-1:0]     adj_rd;
   logic [ADJ_W-1:0]     adj_abs;
   logic [ACC_W-1:0]     acc_abs;
   logic [DMAG_W-1:0]    thr;
   logic                 req_xfer;
   div_ctl_type          div_ctl;
   logic                 div_done;
   logic [ELEM_W-1:0]    div_value;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_xfer  = req_valid && req_ready;

   // Element of the 3x3 minor: row fac skips group c, column skips position r.
   assign term_grp  = skip_idx(fac_ff, idx_ff[1:0]);
   assign term_pos  = skip_idx(perm_col(perm_ff, fac_ff), idx_ff[3:2]);
   assign base_sign = idx_ff[2] ^ idx_ff[0] ^ perm_odd(perm_ff);

   always_comb begin
      case (state_ff)
         ST_FETCH, ST_MUL:  rd_addr = {term_grp, term_pos};
         ST_DFETCH, ST_DMUL: rd_addr = {grp_ff, 2'b00};
         default:           rd_addr = 4'd0;
      endcase
   end

   mi4_store u_store (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (load_cnt_ff),
      .wr_data (req_elem_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_neg    = rd_data[ELEM_W-1];
   assign rd_mag    = rd_neg ? LIMB_W'(-rd_data) : rd_data;
   assign m_limb    = m_ff[LIMB_W*limb_ff +: LIMB_W];
   assign limb_prod = m_limb * rd_mag;
   assign p_in      = p_ff + (PROD_W'(limb_prod) << (LIMB_W * limb_ff));
   assign acc_in    = sgn_ff ? acc_ff - ACC_W'(m_ff) : acc_ff + ACC_W'(m_ff);

   assign adj_rd_idx = (state_ff == ST_DFETCH) ? {2'b00, grp_ff} : idx_ff;
   assign adj_rd     = adj_ff[adj_rd_idx];
   assign adj_abs    = adj_rd[ADJ_W-1] ? ADJ_W'(-adj_rd) : adj_rd;
   assign acc_abs    = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;
   assign thr        = DMAG_W'(min_det_ff) << (3 * FRAC_BITS);

   assign div_ctl.start = div_start_ff;
   assign div_ctl.neg   = adj_rd[ADJ_W-1] ^ det_neg_ff;

   mi4_div u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl     (div_ctl),
      .adj_mag (adj_abs[ADJ_MAG_W-1:0]),
      .dmag    (dmag_ff),
      .done    (div_done),
      .value   (div_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_cnt_ff  <= '0;
         min_det_ff   <= MIN_DET_W'(1);
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (csr_wr_en) begin
            min_det_ff <= csr_wr_data;
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_xfer) begin
                  load_cnt_ff <= load_cnt_ff + 4'd1;
                  if (load_cnt_ff == 4'(NELEM - 1)) begin
                     idx_ff   <= '0;
                     perm_ff  <= '0;
                     fac_ff   <= '0;
                     limb_ff  <= '0;
                     p_ff     <= '0;
                     acc_ff   <= '0;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: state_ff <= ST_MUL;
            ST_MUL: begin
               if (fac_ff == 2'd0) begin
                  m_ff     <= PROD_W'(rd_mag);
                  sgn_ff   <= base_sign ^ rd_neg;
                  fac_ff   <= 2'd1;
                  limb_ff  <= '0;
                  state_ff <= ST_FETCH;
               end else if (limb_ff == 2'(fac_ff - 2'd1)) begin
                  // last limb: product becomes the running magnitude
                  m_ff    <= p_in;
                  p_ff    <= '0;
                  limb_ff <= '0;
                  sgn_ff  <= sgn_ff ^ rd_neg;
                  if (fac_ff == 2'd2) begin
                     state_ff <= ST_ACC;
                  end else begin
                     fac_ff   <= 2'd2;
                     state_ff <= ST_FETCH;
                  end
               end else begin
                  p_ff    <= p_in;
                  limb_ff <= limb_ff + 2'd1;
               end
            end
            ST_ACC: begin
               fac_ff <= '0;
               if (perm_ff == 3'(NPERM - 1)) begin
                  adj_ff[idx_ff] <= acc_in[ADJ_W-1:0];
                  acc_ff         <= '0;
                  perm_ff        <= '0;
                  if (idx_ff == 4'(NELEM - 1)) begin
                     grp_ff   <= '0;
                     state_ff <= ST_DFETCH;
                  end else begin
                     idx_ff   <= idx_ff + 4'd1;
                     state_ff <= ST_FETCH;
                  end
               end else begin
                  acc_ff   <= acc_in;
                  perm_ff  <= perm_ff + 3'd1;
                  state_ff <= ST_FETCH;
               end
            end
            ST_DFETCH: begin
               m_ff     <= PROD_W'(adj_abs[ADJ_MAG_W-1:0]);
               sgn_ff   <= adj_rd[ADJ_W-1];
               limb_ff  <= '0;
               state_ff <= ST_DMUL;
            end
            ST_DMUL: begin
               if (limb_ff == 2'd2) begin
                  m_ff     <= p_in;
                  p_ff     <= '0;
                  sgn_ff   <= sgn_ff ^ rd_neg;
                  state_ff <= ST_DACC;
               end else begin
                  p_ff    <= p_in;
                  limb_ff <= limb_ff + 2'd1;
               end
            end
            ST_DACC: begin
               acc_ff <= acc_in;
               if (grp_ff == 2'd3) begin
                  state_ff <= ST_DABS;
               end else begin
                  grp_ff   <= grp_ff + 2'd1;
                  state_ff <= ST_DFETCH;
               end
            end
            ST_DABS: begin
               dmag_ff    <= acc_abs[DMAG_W-1:0];
               det_neg_ff <= acc_ff[ACC_W-1];
               state_ff   <= ST_CHECK;
            end
            ST_CHECK: begin
               idx_ff <= '0;
               if (dmag_ff == '0 || dmag_ff < thr) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= '0;
                  rsp_index_ff <= '0;
                  rsp_sing_ff  <= 1'b1;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= ST_OUT;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= div_value;
                  rsp_index_ff <= idx_ff;
                  rsp_sing_ff  <= 1'b0;
                  rsp_last_ff  <= (idx_ff == 4'(NELEM - 1));
                  state_ff     <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     idx_ff       <= idx_ff + 4'd1;
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_DIV;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_singular  = rsp_sing_ff;
   assign rsp_last_item = rsp_last_ff;

endmodule

// ----- hw/rtl/mi4_store.sv -----
// Element store: 16 words, one write port and one registered read port.
`timescale 1ns / 1ps
module mi4_store import mi4_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [3:0]        wr_addr,
   input  logic [ELEM_W-1:0] wr_data,
   input  logic [3:0]        rd_addr,
   output logic [ELEM_W-1:0] rd_data
);

   logic [ELEM_W-1:0] mem_ff [NELEM];
   logic [ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mi4_div.sv -----
// Restoring divider: one quotient bit per cycle, saturated to signed 32 bits.
`timescale 1ns / 1ps
module mi4_div import mi4_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctl_type          ctl,
   input  logic [ADJ_MAG_W-1:0] adj_mag,
   input  logic [DMAG_W-1:0]    dmag,
   output logic                 done,
   output logic [ELEM_W-1:0]    value
);

   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_SAT} dv_state_type;

   dv_state_type      state_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  dsh_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [5:0]        cnt_ff;
   logic              neg_ff;
   logic              done_ff;
   logic [ELEM_W-1:0] value_ff;

   logic              ge;
   logic              ovf;
   logic [ELEM_W-1:0] sat_in;

   assign ge  = rem_ff >= dsh_ff;
   assign ovf = quo_ff[QUO_W-1];

   always_comb begin
      if (!neg_ff) begin
         sat_in = (ovf || quo_ff[ELEM_W-1]) ? 32'h7FFF_FFFF : quo_ff[ELEM_W-1:0];
      end else if (ovf || quo_ff[ELEM_W-1:0] > 32'h8000_0000) begin
         sat_in = 32'h8000_0000;
      end else begin
         sat_in = 32'(-quo_ff[ELEM_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            DV_IDLE: begin
               if (ctl.start) begin
                  rem_ff   <= DIV_W'(adj_mag) << (2 * FRAC_BITS);
                  dsh_ff   <= DIV_W'(dmag) << (QUO_W - 1);
                  quo_ff   <= '0;
                  cnt_ff   <= 6'(QUO_W - 1);
                  neg_ff   <= ctl.neg;
                  state_ff <= DV_RUN;
               end
            end
            DV_RUN: begin
               if (ge) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               quo_ff <= {quo_ff[QUO_W-2:0], ge};
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd0) begin
                  state_ff <= DV_SAT;
               end
            end
            DV_SAT: begin
               value_ff <= sat_in;
               done_ff  <= 1'b1;
               state_ff <= DV_IDLE;
            end
            default: state_ff <= DV_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule
